@@ sv/mfrq_pkg.sv @@
// Package for the multilevel feedback run queue.
// Holds parameter defaults, request/response payload types, status codes and
// the controller/datapath interface types. No dependencies.
`default_nettype none

package mfrq_pkg;

  localparam int NUM_PRIORITIES_DEF = 32;
  localparam int QUEUE_DEPTH_DEF    = 16;
  localparam int ID_BITS_DEF        = 8;

  localparam int          SLICE_W     = 24;
  localparam logic [23:0] SLICE_RESET = 24'd1000000;

  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_PICK  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_PICKED = 2'd1,
    ST_IDLE   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] thread_id;
    logic [4:0] thread_priority;
    logic [4:0] owner_best_priority;
    logic       slice_left;
    logic       fixed_priority;
  } in_req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  result_thread;
    logic [4:0]  result_priority;
    logic [28:0] timeslice_ns;
  } out_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic ptr_rd;
    logic exec;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/mfrq_ctrl.sv @@
// Sequencing controller for the run queue: accept, pointer read, update, result.
// Depends on mfrq_pkg.
`default_nettype none

module mfrq_ctrl (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_stall,
  input  mfrq_pkg::dp_sts_t  sts,
  output mfrq_pkg::ctl_cmd_t cmd
);
  import mfrq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ:   state_nxt = S_EXEC;
      S_EXEC:   state_nxt = S_FINISH;
      S_FINISH: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_READ:   cmd.ptr_rd = 1'b1;
      S_EXEC:   cmd.exec   = 1'b1;
      S_FINISH: cmd.finish = !sts.out_busy;
      default:  cmd        = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/mfrq_datapath.sv @@
// Run queue datapath: priority adjust, per-level pointer memory, slot memory,
// timeslice multiply and output register. Depends on mfrq_pkg.
`default_nettype none

module mfrq_datapath #(
  parameter int NUM_PRIORITIES = mfrq_pkg::NUM_PRIORITIES_DEF,
  parameter int QUEUE_DEPTH    = mfrq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS        = mfrq_pkg::ID_BITS_DEF
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  mfrq_pkg::in_req_t  in_req,
  input  wire                logic cfg_wr_en,
  input  wire                logic [mfrq_pkg::SLICE_W-1:0] cfg_wr_data,
  input  wire                logic out_stall,
  output logic               out_valid,
  output mfrq_pkg::out_rsp_t out_rsp,
  input  mfrq_pkg::ctl_cmd_t cmd,
  output mfrq_pkg::dp_sts_t  sts
);
  import mfrq_pkg::*;

  localparam int LVL_W  = $clog2(NUM_PRIORITIES);
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_N = 2 ** (LVL_W + PTR_W);

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [SLICE_W-1:0]        slice_unit_r;
  logic [NUM_PRIORITIES-1:0] nonempty_r;
  logic [NUM_PRIORITIES-1:0] ptr_vld_r;

  logic [PTR_W-1:0]  head_mem [NUM_PRIORITIES];
  logic [PTR_W-1:0]  tail_mem [NUM_PRIORITIES];
  logic [FILL_W-1:0] fill_mem [NUM_PRIORITIES];
  logic [ID_BITS-1:0] slot_mem [SLOT_N];

  in_req_t            req_r;
  logic [LVL_W-1:0]   lvl_r;
  logic               idle_r;
  logic [PTR_W-1:0]   head_r, tail_r;
  logic [FILL_W-1:0]  fill_r;
  logic               rvld_r;
  logic               full_r;
  logic [ID_BITS-1:0] slot_r;
  out_rsp_t           out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [LVL_W-1:0]          sat_lvl, adj_lvl, pick_lvl;
  logic [NUM_PRIORITIES-1:0] le_mask;
  logic                      any_le, any_gt;
  logic [PTR_W-1:0]          head_cur, tail_cur;
  logic [FILL_W-1:0]         fill_cur;
  logic                      full, is_pick, do_push, do_pop;
  logic [LVL_W:0]            lvl_p1;
  logic [LVL_W+SLICE_W:0]    slice_prod;

  always_comb begin
    if (int'(in_req.thread_priority) >= NUM_PRIORITIES) begin
      sat_lvl = LVL_W'(NUM_PRIORITIES - 1);
    end else begin
      sat_lvl = LVL_W'(in_req.thread_priority);
    end
    for (int i = 0; i < NUM_PRIORITIES; i++) begin
      le_mask[i] = (i <= int'(sat_lvl));
    end
    any_le  = |(nonempty_r & le_mask);
    any_gt  = |(nonempty_r & ~le_mask);
    adj_lvl = sat_lvl;
    if (!in_req.fixed_priority) begin
      if (in_req.slice_left) begin
        if (int'(sat_lvl) > int'(in_req.owner_best_priority)) adj_lvl = sat_lvl - 1'b1;
      end else if (!any_le && any_gt) begin
        adj_lvl = sat_lvl + 1'b1;
      end
    end
    pick_lvl = '0;
    for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
      if (nonempty_r[i]) pick_lvl = LVL_W'(i);
    end
  end

  assign head_cur = rvld_r ? head_r : '0;
  assign tail_cur = rvld_r ? tail_r : '0;
  assign fill_cur = rvld_r ? fill_r : '0;
  assign full     = (fill_cur == FILL_W'(QUEUE_DEPTH));
  assign is_pick  = (req_r.command == CMD_PICK);
  assign do_push  = cmd.exec && !is_pick && !full;
  assign do_pop   = cmd.exec && is_pick && !idle_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req;
      lvl_r  <= (in_req.command == CMD_PICK) ? pick_lvl : adj_lvl;
      idle_r <= ~|nonempty_r;
    end
    if (cmd.ptr_rd) begin
      head_r <= head_mem[lvl_r];
      tail_r <= tail_mem[lvl_r];
      fill_r <= fill_mem[lvl_r];
      rvld_r <= ptr_vld_r[lvl_r];
    end
    if (cmd.exec) full_r <= full;
    if (do_push) slot_mem[{lvl_r, tail_cur}] <= ID_BITS'(req_r.thread_id);
    if (do_pop) slot_r <= slot_mem[{lvl_r, head_cur}];
    if (do_push || do_pop) begin
      head_mem[lvl_r] <= do_pop ? next_ptr(head_cur) : head_cur;
      tail_mem[lvl_r] <= do_push ? next_ptr(tail_cur) : tail_cur;
      fill_mem[lvl_r] <= do_push ? fill_cur + 1'b1 : fill_cur - 1'b1;
    end
    if (cmd.finish) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_unit_r <= SLICE_RESET;
      nonempty_r   <= '0;
      ptr_vld_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) slice_unit_r <= cfg_wr_data;
      if (do_push || do_pop) ptr_vld_r[lvl_r] <= 1'b1;
      if (do_push) nonempty_r[lvl_r] <= 1'b1;
      if (do_pop) nonempty_r[lvl_r] <= (fill_cur != FILL_W'(1));
      out_valid_r <= out_valid_nxt;
    end
  end

  assign lvl_p1     = {1'b0, lvl_r} + 1'b1;
  assign slice_prod = (LVL_W+SLICE_W+1)'(lvl_p1) * (LVL_W+SLICE_W+1)'(slice_unit_r);

  always_comb begin
    out_nxt = '0;
    if (is_pick) begin
      if (idle_r) begin
        out_nxt.status = ST_IDLE;
      end else begin
        out_nxt.status          = ST_PICKED;
        out_nxt.result_thread   = 8'(slot_r);
        out_nxt.result_priority = 5'(lvl_r);
        out_nxt.timeslice_ns    = 29'(slice_prod);
      end
    end else begin
      out_nxt.status          = full_r ? ST_FULL : ST_STORED;
      out_nxt.result_thread   = 8'(ID_BITS'(req_r.thread_id));
      out_nxt.result_priority = 5'(lvl_r);
    end
  end

  assign out_valid_nxt = cmd.finish || (out_valid_r && out_stall);
  assign sts.out_busy  = out_valid_r && out_stall;
  assign out_valid     = out_valid_r;
  assign out_rsp       = out_r;

  a_push_marks_level: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> nonempty_r[lvl_r])
    else $error("level not marked nonempty after store");

  a_pop_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> nonempty_r[lvl_r] && fill_cur != '0)
    else $error("pick from a level with no entries");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> int'(fill_cur) <= QUEUE_DEPTH)
    else $error("fill count above queue depth");

  a_pick_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture && in_req.command == CMD_PICK && (|nonempty_r) |=> !idle_r)
    else $error("idle reported while a level waits");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("result shown without a finished request");

endmodule

`default_nettype wire

@@ sv/multilevel_feedback_run_queue.sv @@
// Multilevel feedback run queue, top level.
// Steps per request: accept, pointer read, queue update, result with timeslice
// multiply. in_stall is high outside idle, so a new request is taken only after
// the last result is registered, which waits while an earlier result is stalled.
// Reset (rst_n low, synchronous): controller idle, all levels empty, slice unit
// back to its default; slot storage is not cleared and needs no clearing pass.
`default_nettype none

module multilevel_feedback_run_queue #(
  parameter int NUM_PRIORITIES = mfrq_pkg::NUM_PRIORITIES_DEF,
  parameter int QUEUE_DEPTH    = mfrq_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_BITS        = mfrq_pkg::ID_BITS_DEF
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_stall,
  input  mfrq_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  wire                logic out_stall,
  output mfrq_pkg::out_rsp_t out_rsp,
  input  wire                logic cfg_wr_en,
  input  wire                logic [mfrq_pkg::SLICE_W-1:0] cfg_wr_data
);
  import mfrq_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  mfrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mfrq_datapath #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .ID_BITS        (ID_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire
